>>> hw/rtl/bced_pkg.sv
// Package with the types, constants and helpers shared by the button event detector.
`timescale 1ns / 1ps

package bced_pkg;

    // Width of the press, release and tick counters.
    localparam int COUNT_WIDTH = 16;
    // Width of the configuration registers and of the count fields of a result.
    localparam int CFG_WIDTH   = 16;
    localparam int FIELD_WIDTH = 16;
    // Width at which counters and configuration values are compared.
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET     = CFG_WIDTH'(2);
    localparam logic [CFG_WIDTH-1:0] COMBO_WINDOW_RESET = CFG_WIDTH'(20);
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET   = CFG_WIDTH'(100);

    typedef enum logic [1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_COMBO_WINDOW = 2'd1,
        CFG_LONG_PRESS   = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_HELD     = 4'b0100,
        PH_RELEASED = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_PRESS         = 3'd1,
        EV_COMBO         = 3'd2,
        EV_LONG_PRESS    = 3'd3,
        EV_LONG_RELEASE  = 3'd4,
        EV_RELEASE       = 3'd5,
        EV_COMBO_RELEASE = 3'd6
    } t_event;

    typedef struct packed {
        logic pressed;
        logic clear;
    } t_in_item;

    typedef struct packed {
        t_event                 event_res;
        logic [FIELD_WIDTH-1:0] press_count;
        logic [FIELD_WIDTH-1:0] release_count;
    } t_out_item;

    // Saturating increment.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [CMP_WIDTH-1:0] cnt_ext(input logic [COUNT_WIDTH-1:0] v);
        return CMP_WIDTH'(v);
    endfunction

    function automatic logic [CMP_WIDTH-1:0] cfg_ext(input logic [CFG_WIDTH-1:0] v);
        return CMP_WIDTH'(v);
    endfunction

    // Low bits of a counter as carried in a result.
    function automatic logic [FIELD_WIDTH-1:0] cnt_field(input logic [COUNT_WIDTH-1:0] v);
        logic [CMP_WIDTH-1:0] w;
        w = CMP_WIDTH'(v);
        return w[FIELD_WIDTH-1:0];
    endfunction

endpackage

>>> hw/rtl/button_combo_event_detector.sv
// Button debounce, multi-click and long-press event detector.
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-----------------------------------------
// in      | input     | i_in_valid / o_in_stall | i_in_data  (pressed, clear)
// out     | output    | o_out_valid / i_out_stall | o_out_data (event_res, press_count,
//         |           |                         |             release_count)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Every accepted transaction on the input channel produces exactly one result
// transaction; it is registered in the output register or in the skid register.
// One item is accepted per cycle unless the input is stalled; the phase machine and
// all counters update on acceptance, so back-to-back items see each other's state.
// Reset (synchronous, active low) returns the phase machine to idle, zeroes
// all counters and loads the register defaults (2, 20, 100).
// A stall on the output first fills a one-entry skid register; the input is
// stalled only while that skid register is full, so no result is lost.
// Configuration writes are always ready and take effect on the next item.

module button_combo_event_detector
    import bced_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    // Configuration registers.
    logic [CFG_WIDTH-1:0] r_debounce_ticks;
    logic [CFG_WIDTH-1:0] r_combo_window_ticks;
    logic [CFG_WIDTH-1:0] r_long_press_ticks;

    // Detector state.
    t_phase                 r_phase,          n_phase;
    logic [COUNT_WIDTH-1:0] r_held_ticks,     n_held_ticks;
    logic [COUNT_WIDTH-1:0] r_released_ticks, n_released_ticks;
    logic [COUNT_WIDTH-1:0] r_presses,        n_presses;
    logic [COUNT_WIDTH-1:0] r_releases,       n_releases;
    t_event                 n_event;

    // Output register and skid register.
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_skid_valid;
    t_out_item r_skid_data;

    logic      in_accept;
    logic      out_take;
    t_out_item n_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_out_stall;

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks     <= DEBOUNCE_RESET;
            r_combo_window_ticks <= COMBO_WINDOW_RESET;
            r_long_press_ticks   <= LONG_PRESS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:     r_debounce_ticks     <= i_cfg_data;
                CFG_COMBO_WINDOW: r_combo_window_ticks <= i_cfg_data;
                CFG_LONG_PRESS:   r_long_press_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and event for the item on the input port.
    always_comb begin
        logic [COUNT_WIDTH-1:0] held_inc;
        logic [COUNT_WIDTH-1:0] rel_inc;
        logic [COUNT_WIDTH-1:0] press_inc;

        held_inc  = sat_inc(r_held_ticks);
        rel_inc   = sat_inc(r_released_ticks);
        press_inc = sat_inc(r_presses);

        n_phase          = r_phase;
        n_held_ticks     = r_held_ticks;
        n_released_ticks = r_released_ticks;
        n_presses        = r_presses;
        n_releases       = r_releases;
        n_event          = EV_NONE;

        if (i_in_data.clear) begin
            n_phase          = PH_IDLE;
            n_held_ticks     = '0;
            n_released_ticks = '0;
            n_presses        = '0;
            n_releases       = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    // A new sequence starts from zero on the first pressed sample.
                    if (i_in_data.pressed) begin
                        n_held_ticks     = '0;
                        n_released_ticks = '0;
                        n_presses        = '0;
                        n_releases       = '0;
                        n_phase          = PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE: begin
                    if (i_in_data.pressed) begin
                        n_held_ticks = held_inc;
                        if (cnt_ext(held_inc) > cfg_ext(r_debounce_ticks)) begin
                            n_presses = press_inc;
                            n_phase   = PH_HELD;
                            n_event   = (press_inc == CNT_ONE) ? EV_PRESS : EV_COMBO;
                        end
                    end else begin
                        // Bounce: back to idle, closing the sequence if releases were already seen.
                        if (r_releases == CNT_ONE) begin
                            n_event = EV_RELEASE;
                        end else if (r_releases > CNT_ONE) begin
                            n_event = EV_COMBO_RELEASE;
                        end
                        n_phase = PH_IDLE;
                    end
                end
                PH_HELD: begin
                    if (i_in_data.pressed) begin
                        // The long press fires only on the tick that reaches the limit.
                        if (r_held_ticks != CNT_MAX) begin
                            n_held_ticks = held_inc;
                            if (cnt_ext(held_inc) == cfg_ext(r_long_press_ticks)) begin
                                n_event = EV_LONG_PRESS;
                            end
                        end
                    end else begin
                        n_releases = sat_inc(r_releases);
                        n_phase    = PH_RELEASED;
                    end
                end
                PH_RELEASED: begin
                    if (cnt_ext(r_held_ticks) >= cfg_ext(r_long_press_ticks)) begin
                        n_event = EV_LONG_RELEASE;
                        n_phase = PH_IDLE;
                    end else if (i_in_data.pressed) begin
                        n_held_ticks     = '0;
                        n_released_ticks = '0;
                        n_phase          = PH_DEBOUNCE;
                    end else begin
                        n_released_ticks = rel_inc;
                        if (cnt_ext(rel_inc) >= cfg_ext(r_combo_window_ticks)) begin
                            n_event = (r_releases == CNT_ONE) ? EV_RELEASE : EV_COMBO_RELEASE;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_result.event_res     = n_event;
        n_result.press_count   = cnt_field(n_presses);
        n_result.release_count = cnt_field(n_releases);
    end

    // State update on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_held_ticks     <= '0;
            r_released_ticks <= '0;
            r_presses        <= '0;
            r_releases       <= '0;
        end else if (in_accept) begin
            r_phase          <= n_phase;
            r_held_ticks     <= n_held_ticks;
            r_released_ticks <= n_released_ticks;
            r_presses        <= n_presses;
            r_releases       <= n_releases;
        end
    end

    // Output register with skid. The skid register holds a result that arrived
    // while the output was stalled; it drains into the output register first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_data <= n_result;
            end else begin
                r_skid_data <= n_result;
            end
        end
    end

    // The skid register is only filled behind a waiting output result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register is empty");

    // An accepted clear leaves the machine idle with every count at zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.clear) |=>
            (r_phase == PH_IDLE && r_presses == '0 && r_releases == '0 &&
             r_held_ticks == '0 && r_released_ticks == '0))
        else $error("clear did not return the detector to idle");

    // A button in the held phase has always had at least one accepted press.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HELD) |-> (r_presses != '0))
        else $error("held phase reached without an accepted press");

    // A result that goes out was produced by an accepted transaction or drained
    // from the skid register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_skid_valid && !in_accept) |=> !r_out_valid)
        else $error("output result appeared without an accepted transaction");

endmodule
